>>> design/m2alu_pkg.sv
// Shared codes, defaults and the control group of the 2x2 matrix ALU.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package m2alu_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACT_W          = 4;

    localparam logic [ACT_W-1:0] ACT_ADD       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SUB       = 4'd1;
    localparam logic [ACT_W-1:0] ACT_MUL       = 4'd2;
    localparam logic [ACT_W-1:0] ACT_SCALE     = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DET       = 4'd4;
    localparam logic [ACT_W-1:0] ACT_TRANSPOSE = 4'd5;
    localparam logic [ACT_W-1:0] ACT_INVERSE   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_TRACE     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_EQUAL     = 4'd8;

    // Control that travels with an item from the front stages to the output.
    typedef struct packed {
        logic inv;   // inverse was asked for
        logic zero;  // determinant of A is zero
        logic same;  // equality flag, already final
    } ctl_t;

endpackage

`default_nettype wire

>>> design/m2alu_if.sv
// Channel interfaces of the 2x2 matrix ALU: request and response.
// Depends on m2alu_pkg for the default data width.
`default_nettype none

interface m2alu_in_if #(
    parameter int DW = m2alu_pkg::DATA_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [m2alu_pkg::ACT_W-1:0]    action;
    logic signed [DW-1:0]           a00;
    logic signed [DW-1:0]           a01;
    logic signed [DW-1:0]           a10;
    logic signed [DW-1:0]           a11;
    logic signed [DW-1:0]           b00;
    logic signed [DW-1:0]           b01;
    logic signed [DW-1:0]           b10;
    logic signed [DW-1:0]           b11;
    logic signed [DW-1:0]           factor;

    modport source (output valid, action, a00, a01, a10, a11, b00, b01, b10, b11, factor,
                    input ready);
    modport sink (input valid, action, a00, a01, a10, a11, b00, b01, b10, b11, factor,
                  output ready);
endinterface

interface m2alu_out_if #(
    parameter int DW = m2alu_pkg::DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r00;
    logic signed [DW-1:0] r01;
    logic signed [DW-1:0] r10;
    logic signed [DW-1:0] r11;
    logic                 singular;
    logic                 same;

    modport source (output valid, r00, r01, r10, r11, singular, same, input ready);
    modport sink (input valid, r00, r01, r10, r11, singular, same, output ready);
endinterface

`default_nettype wire

>>> design/m2alu_front.sv
// Front three stages: multiplies, sums, shift with saturation, and
// divider setup for the inverse. Depends on m2alu_pkg.
`default_nettype none

module m2alu_front #(
    parameter int W = m2alu_pkg::DATA_WIDTH_DEF,
    parameter int F = m2alu_pkg::FRAC_BITS_DEF,
    parameter int SW = 4 * m2alu_pkg::DATA_WIDTH_DEF + $bits(m2alu_pkg::ctl_t)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [m2alu_pkg::ACT_W-1:0]   action,
    input  wire logic signed [W-1:0]           a00,
    input  wire logic signed [W-1:0]           a01,
    input  wire logic signed [W-1:0]           a10,
    input  wire logic signed [W-1:0]           a11,
    input  wire logic signed [W-1:0]           b00,
    input  wire logic signed [W-1:0]           b01,
    input  wire logic signed [W-1:0]           b10,
    input  wire logic signed [W-1:0]           b11,
    input  wire logic signed [W-1:0]           factor,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [W+2*F-1:0]                   num [4],
    output logic [2*W-1:0]                     den,
    output logic [3:0]                         neg,
    output logic [3:0]                         ovf,
    output logic [SW-1:0]                      side
);

    localparam int PW   = 2 * W;
    localparam int SUMW = 2 * W + 1;
    localparam int NW   = W + 2 * F;
    localparam int XW   = 3 * W + 2 * F;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_narrow(input logic [W:0] v);
        if (v[W] != v[W-1])
            return v[W] ? MINV : MAXV;
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_wide(input logic [SUMW-1:0] v);
        if (!(&v[SUMW-1:W-1]) && (|v[SUMW-1:W-1]))
            return v[SUMW-1] ? MINV : MAXV;
        return v[W-1:0];
    endfunction

    logic signed [W-1:0] a [4];
    logic signed [W-1:0] b [4];
    assign a[0] = a00;
    assign a[1] = a01;
    assign a[2] = a10;
    assign a[3] = a11;
    assign b[0] = b00;
    assign b[1] = b01;
    assign b[2] = b10;
    assign b[3] = b11;

    // Stage 1: eight shared multipliers, element-wise ops, adjugate.
    logic signed [W-1:0]  mx0 [4];
    logic signed [W-1:0]  my0 [4];
    logic signed [W-1:0]  mx1 [4];
    logic signed [W-1:0]  my1 [4];
    logic signed [PW-1:0] p0_next [4];
    logic signed [PW-1:0] p1_next [4];
    logic [W-1:0]         simp_next [4];
    logic                 same_next;
    logic signed [W:0]    adj_next [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mx0[l] = '0;
            my0[l] = '0;
            mx1[l] = '0;
            my1[l] = '0;
        end
        case (action)
            m2alu_pkg::ACT_MUL:
            begin
                mx0[0] = a00; my0[0] = b00; mx1[0] = a01; my1[0] = b10;
                mx0[1] = a00; my0[1] = b01; mx1[1] = a01; my1[1] = b11;
                mx0[2] = a10; my0[2] = b00; mx1[2] = a11; my1[2] = b10;
                mx0[3] = a10; my0[3] = b01; mx1[3] = a11; my1[3] = b11;
            end
            m2alu_pkg::ACT_SCALE:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    mx0[l] = a[l];
                    my0[l] = factor;
                end
            end
            m2alu_pkg::ACT_DET, m2alu_pkg::ACT_INVERSE:
            begin
                mx0[0] = a00; my0[0] = a11; mx1[0] = a01; my1[0] = a10;
            end
            default:
            begin
            end
        endcase
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_mult
        assign p0_next[l] = mx0[l] * my0[l];
        assign p1_next[l] = mx1[l] * my1[l];
    end

    always_comb
    begin
        for (int e = 0; e < 4; e++)
            simp_next[e] = '0;
        same_next = 1'b0;
        case (action)
            m2alu_pkg::ACT_ADD:
            begin
                for (int e = 0; e < 4; e++)
                    simp_next[e] = sat_narrow({a[e][W-1], a[e]} + {b[e][W-1], b[e]});
            end
            m2alu_pkg::ACT_SUB:
            begin
                for (int e = 0; e < 4; e++)
                    simp_next[e] = sat_narrow({a[e][W-1], a[e]} - {b[e][W-1], b[e]});
            end
            m2alu_pkg::ACT_TRANSPOSE:
            begin
                simp_next[0] = a00;
                simp_next[1] = a10;
                simp_next[2] = a01;
                simp_next[3] = a11;
            end
            m2alu_pkg::ACT_TRACE:
                simp_next[0] = sat_narrow({a00[W-1], a00} + {a11[W-1], a11});
            m2alu_pkg::ACT_EQUAL:
                same_next = (a00 == b00) && (a01 == b01) && (a10 == b10) && (a11 == b11);
            default:
            begin
            end
        endcase
    end

    assign adj_next[0] = {a11[W-1], a11};
    assign adj_next[1] = -{a01[W-1], a01};
    assign adj_next[2] = -{a10[W-1], a10};
    assign adj_next[3] = {a00[W-1], a00};

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        rdy1, rdy2, rdy3;
    logic signed [PW-1:0]        p0_reg [4];
    logic signed [PW-1:0]        p1_reg [4];
    logic [W-1:0]                simp1_reg [4];
    logic                        same1_reg;
    logic [m2alu_pkg::ACT_W-1:0] act1_reg;
    logic signed [W:0]           adj1_reg [4];

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            simp1_reg <= simp_next;
            same1_reg <= same_next;
            act1_reg  <= action;
            adj1_reg  <= adj_next;
        end
    end

    // Stage 2: dot-product sums; lane 0 subtracts for the determinant.
    logic signed [SUMW-1:0]      sum_next [4];
    logic signed [SUMW-1:0]      sum_reg [4];
    logic [W-1:0]                simp2_reg [4];
    logic                        same2_reg;
    logic [m2alu_pkg::ACT_W-1:0] act2_reg;
    logic signed [W:0]           adj2_reg [4];
    logic                        det_op;

    assign det_op = (act1_reg == m2alu_pkg::ACT_DET) || (act1_reg == m2alu_pkg::ACT_INVERSE);

    for (genvar l = 0; l < 4; l++)
    begin : g_sum
        if (l == 0)
        begin : g_det
            assign sum_next[l] = det_op ? SUMW'(p0_reg[l]) - SUMW'(p1_reg[l])
                                        : SUMW'(p0_reg[l]) + SUMW'(p1_reg[l]);
        end
        else
        begin : g_dot
            assign sum_next[l] = SUMW'(p0_reg[l]) + SUMW'(p1_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            sum_reg   <= sum_next;
            simp2_reg <= simp1_reg;
            same2_reg <= same1_reg;
            act2_reg  <= act1_reg;
            adj2_reg  <= adj1_reg;
        end
    end

    // Stage 3: shift and saturate products, prepare the divider operands.
    logic signed [SUMW-1:0] det;
    logic [SUMW-1:0]        det_abs;
    logic [W-1:0]           rsel_next [4];
    logic [NW-1:0]          num_next [4];
    logic [2*W-1:0]         den_next;
    logic [3:0]             neg_next;
    logic [3:0]             ovf_next;
    m2alu_pkg::ctl_t        ctl_next;

    assign det      = sum_reg[0];
    assign det_abs  = det[SUMW-1] ? SUMW'(-det) : det;
    assign den_next = det_abs[2*W-1:0];

    always_comb
    begin
        logic signed [SUMW-1:0] sh;
        logic [W-1:0]           mag;
        for (int e = 0; e < 4; e++)
        begin
            sh = sum_reg[e] >>> F;
            case (act2_reg)
                m2alu_pkg::ACT_MUL, m2alu_pkg::ACT_SCALE:
                    rsel_next[e] = sat_wide(sh);
                m2alu_pkg::ACT_DET:
                    rsel_next[e] = (e == 0) ? sat_wide(sh) : '0;
                default:
                    rsel_next[e] = simp2_reg[e];
            endcase
            mag = adj2_reg[e][W] ? W'(-adj2_reg[e]) : adj2_reg[e][W-1:0];
            num_next[e] = {mag, {(2*F){1'b0}}};
            neg_next[e] = adj2_reg[e][W] ^ det[SUMW-1];
            // Quotient reaches 2^(W-1) exactly when num >= den * 2^(W-1).
            ovf_next[e] = XW'(num_next[e]) >= (XW'(den_next) << (W - 1));
        end
    end

    assign ctl_next.inv  = (act2_reg == m2alu_pkg::ACT_INVERSE);
    assign ctl_next.zero = (det == '0);
    assign ctl_next.same = same2_reg;

    logic [NW-1:0]  num_reg [4];
    logic [2*W-1:0] den_reg;
    logic [3:0]     neg_reg;
    logic [3:0]     ovf_reg;
    logic [SW-1:0]  side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            neg_reg  <= neg_next;
            ovf_reg  <= ovf_next;
            side_reg <= {rsel_next[3], rsel_next[2], rsel_next[1], rsel_next[0], ctl_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign neg       = neg_reg;
    assign ovf       = ovf_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

>>> design/m2alu_div.sv
// Pipelined restoring divider for the four inverse elements: one quotient
// bit per stage, W-1 stages. Depends on m2alu_pkg for defaults.
`default_nettype none

module m2alu_div #(
    parameter int W = m2alu_pkg::DATA_WIDTH_DEF,
    parameter int F = m2alu_pkg::FRAC_BITS_DEF,
    parameter int SW = 4 * m2alu_pkg::DATA_WIDTH_DEF + $bits(m2alu_pkg::ctl_t)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [W+2*F-1:0]  num [4],
    input  wire logic [2*W-1:0]    den,
    input  wire logic [3:0]        neg,
    input  wire logic [3:0]        ovf,
    input  wire logic [SW-1:0]     side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [W-2:0]           quo [4],
    output logic [3:0]             out_neg,
    output logic [3:0]             out_ovf,
    output logic [SW-1:0]          out_side
);

    localparam int N  = W - 1;
    localparam int NW = W + 2 * F;
    localparam int XW = 3 * W + 2 * F;

    logic [N-1:0]   v_reg;
    logic [N-1:0]   rdy;
    logic [NW-1:0]  rem_reg [N][4];
    logic [W-2:0]   q_reg [N][4];
    logic [2*W-1:0] den_reg [N];
    logic [3:0]     neg_reg [N];
    logic [3:0]     ovf_reg [N];
    logic [SW-1:0]  side_reg [N];

    logic           v_in [N];
    logic [NW-1:0]  rem_in [N][4];
    logic [W-2:0]   q_in [N][4];
    logic [2*W-1:0] den_in [N];
    logic [3:0]     neg_in [N];
    logic [3:0]     ovf_in [N];
    logic [SW-1:0]  side_in [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int BI = N - 1 - k;

        logic [NW-1:0] rem_next [4];
        logic [W-2:0]  q_next [4];

        if (k == 0)
        begin : g_first
            assign v_in[k]    = in_valid;
            assign rem_in[k]  = num;
            assign den_in[k]  = den;
            assign neg_in[k]  = neg;
            assign ovf_in[k]  = ovf;
            assign side_in[k] = side;
            for (genvar e = 0; e < 4; e++)
            begin : g_q0
                assign q_in[k][e] = '0;
            end
        end
        else
        begin : g_chain
            assign v_in[k]    = v_reg[k-1];
            assign rem_in[k]  = rem_reg[k-1];
            assign q_in[k]    = q_reg[k-1];
            assign den_in[k]  = den_reg[k-1];
            assign neg_in[k]  = neg_reg[k-1];
            assign ovf_in[k]  = ovf_reg[k-1];
            assign side_in[k] = side_reg[k-1];
        end

        if (k == N - 1)
        begin : g_last
            assign rdy[k] = !v_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end

        // The remainder stays below den << (BI+1), so one trial subtract
        // decides this quotient bit.
        always_comb
        begin
            logic [XW-1:0] dsh;
            logic [XW-1:0] remx;
            dsh = XW'(den_in[k]) << BI;
            for (int e = 0; e < 4; e++)
            begin
                remx = XW'(rem_in[k][e]);
                if (remx >= dsh)
                begin
                    rem_next[e] = NW'(remx - dsh);
                    q_next[e]   = q_in[k][e] | ((W-1)'(1) << BI);
                end
                else
                begin
                    rem_next[e] = rem_in[k][e];
                    q_next[e]   = q_in[k][e];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_in[k];
                neg_reg[k]  <= neg_in[k];
                ovf_reg[k]  <= ovf_in[k];
                side_reg[k] <= side_in[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= v_in[k];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];
    assign quo       = q_reg[N-1];
    assign out_neg   = neg_reg[N-1];
    assign out_ovf   = ovf_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

>>> design/m2alu_out.sv
// Output register: signs and saturates the inverse quotients and picks the
// final result fields. Depends on m2alu_pkg.
`default_nettype none

module m2alu_out #(
    parameter int W = m2alu_pkg::DATA_WIDTH_DEF,
    parameter int SW = 4 * m2alu_pkg::DATA_WIDTH_DEF + $bits(m2alu_pkg::ctl_t)
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [W-2:0]   quo [4],
    input  wire logic [3:0]     neg,
    input  wire logic [3:0]     ovf,
    input  wire logic [SW-1:0]  side,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [W-1:0]        res [4],
    output logic                singular,
    output logic                same
);

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam int CW = $bits(m2alu_pkg::ctl_t);

    m2alu_pkg::ctl_t ctl;
    logic [W-1:0]    rsel [4];
    logic [W-1:0]    res_next [4];
    logic [W-1:0]    res_reg [4];
    logic            singular_reg;
    logic            same_reg;
    logic            v_reg;

    assign ctl = side[CW-1:0];
    for (genvar e = 0; e < 4; e++)
    begin : g_unpack
        assign rsel[e] = side[CW + e*W +: W];
    end

    always_comb
    begin
        logic [W-1:0] q;
        for (int e = 0; e < 4; e++)
        begin
            q = {1'b0, quo[e]};
            if (!ctl.inv)
                res_next[e] = rsel[e];
            else if (ctl.zero)
                res_next[e] = '0;
            else if (ovf[e])
                res_next[e] = neg[e] ? MINV : MAXV;
            else
                res_next[e] = neg[e] ? W'(-q) : q;
        end
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            res_reg      <= res_next;
            singular_reg <= ctl.inv && ctl.zero;
            same_reg     <= ctl.same;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    assign out_valid = v_reg;
    assign res       = res_reg;
    assign singular  = singular_reg;
    assign same      = same_reg;

`ifndef SYNTHESIS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg && singular_reg) |->
            (res_reg[0] == '0 && res_reg[1] == '0 && res_reg[2] == '0 && res_reg[3] == '0))
        else $error("singular result carries a nonzero element");
    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg && same_reg) |->
            (res_reg[0] == '0 && res_reg[1] == '0 && res_reg[2] == '0 && res_reg[3] == '0))
        else $error("equality result carries a nonzero element");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> !(singular_reg && same_reg))
        else $error("singular and same raised together");
`endif

endmodule

`default_nettype wire

>>> design/matrix2x2_alu.sv
// Top level of the signed fixed-point 2x2 matrix ALU.
// Depends on m2alu_pkg, m2alu_if, m2alu_front, m2alu_div and m2alu_out.
//
//   channel | role   | payload
//   --------+--------+------------------------------------------------
//   req     | sink   | action, a00..a11, b00..b11, factor
//   rsp     | source | r00, r01, r10, r11, singular, same
//
// One transfer is taken every cycle when the response side keeps up.
// The path holds three front stages, one divider stage per
// inverse quotient bit (DATA_WIDTH-1), and the output register.
// Every stage holds its own valid bit; a stalled stage stops only the
// stages behind it, so bubbles close up under backpressure.
// Reset clears the valid bits only; the data registers are not reset.
`default_nettype none

module matrix2x2_alu #(
    parameter int DATA_WIDTH = m2alu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m2alu_pkg::FRAC_BITS_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    m2alu_in_if.sink     req,
    m2alu_out_if.source  rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + 2 * F;
    localparam int SW = 4 * W + $bits(m2alu_pkg::ctl_t);

    logic           f_valid, f_ready;
    logic [NW-1:0]  f_num [4];
    logic [2*W-1:0] f_den;
    logic [3:0]     f_neg, f_ovf;
    logic [SW-1:0]  f_side;

    logic           d_valid, d_ready;
    logic [W-2:0]   d_quo [4];
    logic [3:0]     d_neg, d_ovf;
    logic [SW-1:0]  d_side;

    logic [W-1:0]   res [4];

    m2alu_front #(.W(W), .F(F), .SW(SW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .action    (req.action),
        .a00       (req.a00),
        .a01       (req.a01),
        .a10       (req.a10),
        .a11       (req.a11),
        .b00       (req.b00),
        .b01       (req.b01),
        .b10       (req.b10),
        .b11       (req.b11),
        .factor    (req.factor),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .num       (f_num),
        .den       (f_den),
        .neg       (f_neg),
        .ovf       (f_ovf),
        .side      (f_side)
    );

    m2alu_div #(.W(W), .F(F), .SW(SW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num       (f_num),
        .den       (f_den),
        .neg       (f_neg),
        .ovf       (f_ovf),
        .side      (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .quo       (d_quo),
        .out_neg   (d_neg),
        .out_ovf   (d_ovf),
        .out_side  (d_side)
    );

    m2alu_out #(.W(W), .SW(SW)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .quo       (d_quo),
        .neg       (d_neg),
        .ovf       (d_ovf),
        .side      (d_side),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .res       (res),
        .singular  (rsp.singular),
        .same      (rsp.same)
    );

    assign rsp.r00 = res[0];
    assign rsp.r01 = res[1];
    assign rsp.r10 = res[2];
    assign rsp.r11 = res[3];

endmodule

`default_nettype wire
